### hw/rtl/slfr_pkg.sv
// Shared types, constants and codes for the sync/length frame receiver.
// No dependencies; every other file of the block but slfr_ram refers to it by scoped names.
package slfr_pkg;

    localparam int SLOT_COUNT_DEF    = 4;
    localparam int PAYLOAD_DEPTH_DEF = 256;

    localparam logic [7:0] SYNC_RST       = 8'd0;
    localparam logic [7:0] MIN_LENGTH_RST = 8'd6;
    localparam logic [7:0] MAX_LENGTH_RST = 8'd255;

    localparam logic [1:0] CMD_RX      = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MIN_LENGTH  = 2'd2;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd3;

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] min_length;
        logic [7:0] max_length;
    } t_cfg;

    // Result of one item as decided in the first stage; the payload byte
    // itself arrives from the store in the cycle after.
    typedef struct packed {
        logic [1:0] status;
        logic       frame_done;
        logic [2:0] done_slot;
        logic [7:0] done_length;
        logic       read_valid;
        logic       read_hit;
        logic [7:0] offset;
    } t_res;

endpackage

### hw/rtl/sync_length_frame_receiver_top.sv
// Top level of the sync/length frame receiver with its slot store.
// Depends on slfr_pkg, slfr_ram, slfr_ctrl and slfr_resp.
//
//  Channel | Handshake                   | Beat contents
//  --------+-----------------------------+----------------------------------------------
//  input   | i_in_valid / o_in_ready     | command, rx_byte, slot_select, byte_offset
//  output  | o_out_valid / i_out_ready   | status, frame_done, done_slot/length, read_*
//  config  | i_cfg_valid / o_cfg_ready   | register index and 8-bit write data
//
// One input beat is taken every cycle while o_in_ready is high; the result beat is
// held in the second stage for the payload store read, then in the output register.
// A result waiting at the output does not stop the next beat: the second stage
// still takes one, and only when both stages are full does o_in_ready drop.
// Reset is synchronous and active low; the payload and length stores are not
// cleared, as every readable entry has been written by the frame that filled it.
module sync_length_frame_receiver_top #(
    parameter int SLOT_COUNT    = slfr_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_DEPTH = slfr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_rx_byte,
    input  logic [2:0] i_slot_select,
    input  logic [7:0] i_byte_offset,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic       o_frame_done,
    output logic [2:0] o_done_slot,
    output logic [7:0] o_done_length,
    output logic [7:0] o_read_byte,
    output logic       o_read_valid,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PL_AW   = $clog2(SLOT_COUNT * PAYLOAD_DEPTH);

    slfr_pkg::t_cfg r_cfg;
    slfr_pkg::t_res res;

    logic               in_acc;
    logic               pl_we;
    logic [PL_AW-1:0]   pl_waddr;
    logic [7:0]         pl_wdata;
    logic               pl_re;
    logic [PL_AW-1:0]   pl_raddr;
    logic [7:0]         pl_rdata;
    logic               len_we;
    logic [SLOT_IW-1:0] len_waddr;
    logic [7:0]         len_wdata;
    logic               len_re;
    logic [SLOT_IW-1:0] len_raddr;
    logic [7:0]         len_rdata;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; they are to be written only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= slfr_pkg::SYNC_RST;
            r_cfg.sync_second <= slfr_pkg::SYNC_RST;
            r_cfg.min_length  <= slfr_pkg::MIN_LENGTH_RST;
            r_cfg.max_length  <= slfr_pkg::MAX_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slfr_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                slfr_pkg::CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                slfr_pkg::CFG_MIN_LENGTH:  r_cfg.min_length  <= i_cfg_data;
                slfr_pkg::CFG_MAX_LENGTH:  r_cfg.max_length  <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // First stage: parser, slot flags and the store access for this beat.
    slfr_ctrl #(
        .SLOT_COUNT    (SLOT_COUNT),
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_acc         (in_acc),
        .i_command     (i_command),
        .i_rx_byte     (i_rx_byte),
        .i_slot_select (i_slot_select),
        .i_byte_offset (i_byte_offset),
        .o_res         (res),
        .o_pl_we       (pl_we),
        .o_pl_waddr    (pl_waddr),
        .o_pl_wdata    (pl_wdata),
        .o_pl_re       (pl_re),
        .o_pl_raddr    (pl_raddr),
        .o_len_we      (len_we),
        .o_len_waddr   (len_waddr),
        .o_len_wdata   (len_wdata),
        .o_len_re      (len_re),
        .o_len_raddr   (len_raddr)
    );

    // Payload store: one region of PAYLOAD_DEPTH bytes for each slot.
    slfr_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_COUNT * PAYLOAD_DEPTH)
    ) u_payload (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    // Frame length of each slot, recorded when the slot is claimed.
    slfr_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_COUNT)
    ) u_length (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // Second stage and output register.
    slfr_resp u_resp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (in_acc),
        .i_res         (res),
        .i_pl_rdata    (pl_rdata),
        .i_len_rdata   (len_rdata),
        .i_out_ready   (i_out_ready),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_frame_done  (o_frame_done),
        .o_done_slot   (o_done_slot),
        .o_done_length (o_done_length),
        .o_read_byte   (o_read_byte),
        .o_read_valid  (o_read_valid)
    );

endmodule

### hw/rtl/slfr_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module slfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/slfr_ctrl.sv
// Frame parser, slot flags and store access control (first pipeline stage).
// Depends on slfr_pkg.
module slfr_ctrl #(
    parameter int SLOT_COUNT    = slfr_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_DEPTH = slfr_pkg::PAYLOAD_DEPTH_DEF,
    localparam int SLOT_IW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int PL_AW        = $clog2(SLOT_COUNT * PAYLOAD_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slfr_pkg::t_cfg     i_cfg,
    input  logic               i_acc,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_rx_byte,
    input  logic [2:0]         i_slot_select,
    input  logic [7:0]         i_byte_offset,
    output slfr_pkg::t_res     o_res,
    output logic               o_pl_we,
    output logic [PL_AW-1:0]   o_pl_waddr,
    output logic [7:0]         o_pl_wdata,
    output logic               o_pl_re,
    output logic [PL_AW-1:0]   o_pl_raddr,
    output logic               o_len_we,
    output logic [SLOT_IW-1:0] o_len_waddr,
    output logic [7:0]         o_len_wdata,
    output logic               o_len_re,
    output logic [SLOT_IW-1:0] o_len_raddr
);

    slfr_pkg::t_phase        r_phase, n_phase;
    logic [7:0]              r_exp_len, n_exp_len;
    logic [7:0]              r_cnt, n_cnt;
    logic [SLOT_IW-1:0]      r_cur, n_cur;
    logic [SLOT_COUNT-1:0]   r_active, n_active;
    logic [SLOT_COUNT-1:0]   r_complete, n_complete;

    logic               rx_acc;
    logic               sel_ok;
    logic [SLOT_IW-1:0] sel_idx;
    logic               off_ok;
    logic               slot_ready;
    logic               len_bad;
    logic               free_found;
    logic [SLOT_IW-1:0] free_idx;
    logic [7:0]         cnt_inc;
    logic               last_byte;

    assign rx_acc     = i_acc && (i_command == slfr_pkg::CMD_RX);
    assign sel_ok     = {1'b0, i_slot_select} < 4'(SLOT_COUNT);
    assign sel_idx    = i_slot_select[SLOT_IW-1:0];
    assign off_ok     = {1'b0, i_byte_offset} < 9'(PAYLOAD_DEPTH);
    assign slot_ready = sel_ok && r_active[sel_idx] && r_complete[sel_idx];
    assign len_bad    = (i_rx_byte == 8'd0) || (i_rx_byte < i_cfg.min_length)
                        || (i_rx_byte > i_cfg.max_length);
    assign cnt_inc    = r_cnt + 8'd1;
    assign last_byte  = cnt_inc >= r_exp_len;

    // Lowest slot that is not both active and complete.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!(r_active[i] && r_complete[i])) begin
                free_found = 1'b1;
                free_idx   = SLOT_IW'(i);
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (rx_acc) begin
            case (r_phase)
                slfr_pkg::PH_SYNC1: begin
                    if (i_rx_byte == i_cfg.sync_first) begin
                        n_phase = slfr_pkg::PH_SYNC2;
                    end
                end
                slfr_pkg::PH_SYNC2: begin
                    n_phase = (i_rx_byte == i_cfg.sync_second) ? slfr_pkg::PH_LEN
                                                               : slfr_pkg::PH_SYNC1;
                end
                slfr_pkg::PH_LEN: begin
                    n_phase = (!len_bad && free_found) ? slfr_pkg::PH_DATA
                                                       : slfr_pkg::PH_SYNC1;
                end
                slfr_pkg::PH_DATA: begin
                    if (last_byte) begin
                        n_phase = slfr_pkg::PH_SYNC1;
                    end
                end
                default: begin
                    n_phase = slfr_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_comb begin
        n_exp_len   = r_exp_len;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_active    = r_active;
        n_complete  = r_complete;
        o_res       = '0;
        o_res.offset = i_byte_offset;
        o_pl_we     = 1'b0;
        o_pl_waddr  = PL_AW'(r_cur) * PL_AW'(PAYLOAD_DEPTH) + PL_AW'(r_cnt);
        o_pl_wdata  = i_rx_byte;
        o_pl_re     = 1'b0;
        o_pl_raddr  = PL_AW'(sel_idx) * PL_AW'(PAYLOAD_DEPTH) + PL_AW'(i_byte_offset);
        o_len_we    = 1'b0;
        o_len_waddr = free_idx;
        o_len_wdata = i_rx_byte;
        o_len_re    = 1'b0;
        o_len_raddr = sel_idx;

        if (rx_acc) begin
            case (r_phase)
                slfr_pkg::PH_SYNC1, slfr_pkg::PH_SYNC2: begin
                    n_cnt = 8'd0;
                end
                slfr_pkg::PH_LEN: begin
                    if (len_bad) begin
                        o_res.status = slfr_pkg::ST_RANGE;
                    end else if (!free_found) begin
                        o_res.status = slfr_pkg::ST_FULL;
                    end else begin
                        n_cur                = free_idx;
                        n_exp_len            = i_rx_byte;
                        n_cnt                = 8'd0;
                        n_active[free_idx]   = 1'b1;
                        n_complete[free_idx] = 1'b0;
                        o_len_we             = 1'b1;
                    end
                end
                slfr_pkg::PH_DATA: begin
                    // Bytes beyond the store depth are counted but dropped.
                    o_pl_we = {1'b0, r_cnt} < 9'(PAYLOAD_DEPTH);
                    n_cnt   = cnt_inc;
                    if (last_byte) begin
                        n_complete[r_cur]  = 1'b1;
                        o_res.frame_done   = 1'b1;
                        o_res.done_slot    = 3'(r_cur);
                        o_res.done_length  = r_exp_len;
                        n_cnt              = 8'd0;
                        n_exp_len          = 8'd0;
                    end
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end

        if (i_acc && (i_command == slfr_pkg::CMD_READ)) begin
            o_res.read_valid = slot_ready;
            o_res.read_hit   = slot_ready && off_ok;
            o_pl_re          = slot_ready && off_ok;
            o_len_re         = slot_ready && off_ok;
        end

        if (i_acc && (i_command == slfr_pkg::CMD_RELEASE) && sel_ok) begin
            n_active[sel_idx]   = 1'b0;
            n_complete[sel_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= slfr_pkg::PH_SYNC1;
            r_exp_len  <= 8'd0;
            r_cnt      <= 8'd0;
            r_cur      <= '0;
            r_active   <= '0;
            r_complete <= '0;
        end else begin
            r_phase    <= n_phase;
            r_exp_len  <= n_exp_len;
            r_cnt      <= n_cnt;
            r_cur      <= n_cur;
            r_active   <= n_active;
            r_complete <= n_complete;
        end
    end

endmodule

### hw/rtl/slfr_resp.sv
// Second stage and output register: merges store read data into the result.
// Depends on slfr_pkg.
module slfr_resp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  slfr_pkg::t_res i_res,
    input  logic [7:0]     i_pl_rdata,
    input  logic [7:0]     i_len_rdata,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic           o_frame_done,
    output logic [2:0]     o_done_slot,
    output logic [7:0]     o_done_length,
    output logic [7:0]     o_read_byte,
    output logic           o_read_valid
);

    logic           r_s1_vld;
    slfr_pkg::t_res r_s1;
    logic           r_out_vld;
    logic [1:0]     r_status;
    logic           r_frame_done;
    logic [2:0]     r_done_slot;
    logic [7:0]     r_done_length;
    logic [7:0]     r_read_byte;
    logic           r_read_valid;

    logic       s1_move;
    logic [7:0] s1_byte;

    assign s1_move    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign s1_byte    = (r_s1.read_hit && (r_s1.offset < i_len_rdata)) ? i_pl_rdata : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1 <= i_res;
        end
        if (s1_move) begin
            r_status      <= r_s1.status;
            r_frame_done  <= r_s1.frame_done;
            r_done_slot   <= r_s1.done_slot;
            r_done_length <= r_s1.done_length;
            r_read_byte   <= s1_byte;
            r_read_valid  <= r_s1.read_valid;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_status;
    assign o_frame_done  = r_frame_done;
    assign o_done_slot   = r_done_slot;
    assign o_done_length = r_done_length;
    assign o_read_byte   = r_read_byte;
    assign o_read_valid  = r_read_valid;

endmodule

### hw/rtl/slfr_checker.sv
// Port-level checks on the result channel of the frame receiver, and their bind.
// Depends on slfr_pkg and sync_length_frame_receiver_top.
module slfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic       o_frame_done,
    input logic [2:0] o_done_slot,
    input logic [7:0] o_done_length,
    input logic [7:0] o_read_byte,
    input logic       o_read_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_read_byte) && $stable(o_done_length))
        else $error("result beat changed while stalled");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_status == slfr_pkg::ST_OK
            && !o_read_valid && o_read_byte == 8'd0 && o_done_length != 8'd0)
        else $error("completed frame carries stray fields");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_byte == 8'd0)
        else $error("payload byte returned for an unreadable slot");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != slfr_pkg::ST_OK |-> !o_frame_done
            && o_done_length == 8'd0 && o_done_slot == 3'd0 && !o_read_valid)
        else $error("error status combined with frame or read fields");

endmodule

bind sync_length_frame_receiver_top slfr_checker u_slfr_checker (.*);
